// File: src/assert_macros.svh
// Assertion macros used by the checker file fdp_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FDP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fdp assertion failed");

// Next-cycle implication, disabled during reset.
`define FDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fdp assertion failed");

`endif

// File: src/fdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdp_pkg
// Types and constants of the fraction decimal period core.
// ----------------------------------------------------------------------------
package fdp_pkg;

   localparam int DEN_BITS_DEFAULT = 16;
   localparam int FIELD_BITS       = 16;
   localparam int CNT_BITS         = 5;

   localparam logic [1:0] KIND_TERM     = 2'd0;
   localparam logic [1:0] KIND_PURE     = 2'd1;
   localparam logic [1:0] KIND_MIXED    = 2'd2;
   localparam logic [1:0] KIND_ZERO_DEN = 2'd3;

   typedef struct packed {
      logic [15:0] numerator;
      logic [15:0] denominator;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] reduced_numerator;
      logic [15:0] reduced_denominator;
      logic [4:0]  preperiod_digits;
      logic [15:0] period_digits;
      logic [15:0] repeat_first;
      logic [16:0] repeat_last;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK_ZERO,
      ST_GCD_TEST,
      ST_GCD_WAIT,
      ST_NUM_START,
      ST_NUM_WAIT,
      ST_DEN_START,
      ST_DEN_WAIT,
      ST_TWOS,
      ST_FIVES,
      ST_CLASSIFY,
      ST_ORD_DBL_SAVE,
      ST_ORD_DBL1,
      ST_ORD_DBL2,
      ST_ORD_ADD,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_GCD_STEP,
      OP_NUM_LOAD,
      OP_DEN_LOAD,
      OP_TWO_STEP,
      OP_FIVE_STEP,
      OP_ORD_INIT,
      OP_DBL_SAVE,
      OP_DBL,
      OP_ADD
   } dp_op_type;

   typedef enum logic [1:0] {
      DIV_GCD,
      DIV_NUM,
      DIV_DEN
   } div_sel_type;

   typedef struct packed {
      dp_op_type   op;
      logic        div_start;
      div_sel_type div_sel;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic den_zero;
      logic y_zero;
      logic div_done;
      logic rest_five;
      logic rest_odd;
      logic rest_one;
      logic ord_last;
   } sts_type;

endpackage

// File: src/fdp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fdp_div #(
   parameter int W = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);

   localparam int CntW = $clog2(W + 1);

   logic            busy_ff;
   logic            done_ff;
   logic [CntW-1:0] cnt_ff;
   logic [W-1:0]    rem_ff;
   logic [W-1:0]    quo_ff;
   logic [W-1:0]    dsr_ff;
   logic [W:0]      trial;
   logic [W:0]      diff;
   logic            ge;

   always_comb begin
      trial = {rem_ff, quo_ff[W-1]};
      diff  = trial - {1'b0, dsr_ff};
      ge    = (trial >= {1'b0, dsr_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CntW'(W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CntW'(1);
            if (cnt_ff == CntW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[W-1:0] : trial[W-1:0];
         quo_ff <= {quo_ff[W-2:0], ge};
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: src/fdp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdp_datapath
// Term registers, gcd reduction, 2/5 stripping, order search and result.
// ----------------------------------------------------------------------------
module fdp_datapath
   import fdp_pkg::*;
#(
   parameter int DEN_BITS = DEN_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_data
);

   localparam int W = (DEN_BITS < FIELD_BITS) ? DEN_BITS : FIELD_BITS;
   // n / 5 == (n * ceil(2^18 / 5)) >> 18 for every n below 2^18
   localparam logic [33:0] FiveRecip = 34'd52429;
   localparam int          FiveShift = 18;

   logic [W-1:0]        num_ff, den_ff, x_ff, y_ff, rest_ff;
   logic [W-1:0]        acc_ff, save_ff, period_ff;
   logic [CNT_BITS-1:0] twos_ff, fives_ff;
   logic                den_zero_ff;
   rsp_type             rsp_ff;

   logic [W-1:0]        div_a, div_b, quo, rem;
   logic                div_done;
   logic [33:0]         five_prod;
   logic [W-1:0]        five_q;
   logic [W+1:0]        five_back;
   logic [W-1:0]        mod_b;
   logic [W:0]          mod_sum;
   logic [W-1:0]        mod_res;
   logic [W:0]          period_next;
   logic [CNT_BITS-1:0] pre;
   rsp_type             rsp_in;

   always_comb begin
      case (cmd.div_sel)
         DIV_GCD:  begin div_a = x_ff;    div_b = y_ff;   end
         DIV_NUM:  begin div_a = num_ff;  div_b = x_ff;   end
         DIV_DEN:  begin div_a = den_ff;  div_b = x_ff;   end
         default:  begin div_a = x_ff;    div_b = y_ff;   end
      endcase
   end

   fdp_div #(.W(W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   // divide by five via reciprocal multiply
   always_comb begin
      five_prod = 34'(rest_ff) * FiveRecip;
      five_q    = W'(five_prod[33:FiveShift]);
      five_back = {five_q, 2'b00} + (W+2)'(five_q);
   end

   // modular add/double: both operands below rest
   always_comb begin
      mod_b       = (cmd.op == OP_ADD) ? save_ff : acc_ff;
      mod_sum     = {1'b0, acc_ff} + {1'b0, mod_b};
      mod_res     = (mod_sum >= {1'b0, rest_ff}) ? W'(mod_sum - {1'b0, rest_ff})
                                                 : mod_sum[W-1:0];
      period_next = {1'b0, period_ff} + (W+1)'(1);
   end

   always_comb begin
      sts.den_zero  = den_zero_ff;
      sts.y_zero    = (y_ff == '0);
      sts.div_done  = div_done;
      sts.rest_five = (five_back == {2'b00, rest_ff});
      sts.rest_odd  = rest_ff[0];
      sts.rest_one  = (rest_ff == W'(1));
      sts.ord_last  = (mod_res == W'(1)) || (period_next >= {1'b0, rest_ff});
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            num_ff      <= req_data.numerator[W-1:0];
            den_ff      <= req_data.denominator[W-1:0];
            x_ff        <= req_data.numerator[W-1:0];
            y_ff        <= req_data.denominator[W-1:0];
            den_zero_ff <= (req_data.denominator[W-1:0] == '0);
            twos_ff     <= '0;
            fives_ff    <= '0;
         end
         OP_GCD_STEP: begin
            x_ff <= y_ff;
            y_ff <= rem;
         end
         OP_NUM_LOAD: num_ff <= quo;
         OP_DEN_LOAD: begin
            den_ff  <= quo;
            rest_ff <= quo;
         end
         OP_TWO_STEP: begin
            rest_ff <= rest_ff >> 1;
            twos_ff <= twos_ff + CNT_BITS'(1);
         end
         OP_FIVE_STEP: begin
            rest_ff  <= five_q;
            fives_ff <= fives_ff + CNT_BITS'(1);
         end
         OP_ORD_INIT: begin
            acc_ff    <= W'(1);
            period_ff <= '0;
         end
         OP_DBL_SAVE: begin
            acc_ff  <= mod_res;
            save_ff <= mod_res;
         end
         OP_DBL: acc_ff <= mod_res;
         OP_ADD: begin
            acc_ff    <= mod_res;
            period_ff <= period_next[W-1:0];
         end
         default: ;
      endcase
   end

   always_comb begin
      pre    = (twos_ff > fives_ff) ? twos_ff : fives_ff;
      rsp_in = '0;
      if (den_zero_ff) begin
         rsp_in.kind = KIND_ZERO_DEN;
      end else begin
         rsp_in.reduced_numerator   = 16'(num_ff);
         rsp_in.reduced_denominator = 16'(den_ff);
         rsp_in.preperiod_digits    = pre;
         if (rest_ff == W'(1)) begin
            rsp_in.kind = KIND_TERM;
         end else begin
            rsp_in.kind          = (pre == '0) ? KIND_PURE : KIND_MIXED;
            rsp_in.period_digits = 16'(period_ff);
            rsp_in.repeat_first  = 16'(pre) + 16'd1;
            rsp_in.repeat_last   = 17'(pre) + 17'(period_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: src/fdp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdp_ctrl
// Sequencer for one fraction at a time, plus the result valid flag.
// ----------------------------------------------------------------------------
module fdp_ctrl
   import fdp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:         if (req_valid) state_in = ST_CHECK_ZERO;
         ST_CHECK_ZERO:   state_in = sts.den_zero ? ST_FINISH : ST_GCD_TEST;
         ST_GCD_TEST:     state_in = sts.y_zero ? ST_NUM_START : ST_GCD_WAIT;
         ST_GCD_WAIT:     if (sts.div_done) state_in = ST_GCD_TEST;
         ST_NUM_START:    state_in = ST_NUM_WAIT;
         ST_NUM_WAIT:     if (sts.div_done) state_in = ST_DEN_START;
         ST_DEN_START:    state_in = ST_DEN_WAIT;
         ST_DEN_WAIT:     if (sts.div_done) state_in = ST_TWOS;
         ST_TWOS:         if (sts.rest_odd) state_in = ST_FIVES;
         ST_FIVES:        state_in = sts.rest_five ? ST_FIVES : ST_CLASSIFY;
         ST_CLASSIFY:     state_in = sts.rest_one ? ST_FINISH : ST_ORD_DBL_SAVE;
         ST_ORD_DBL_SAVE: state_in = ST_ORD_DBL1;
         ST_ORD_DBL1:     state_in = ST_ORD_DBL2;
         ST_ORD_DBL2:     state_in = ST_ORD_ADD;
         ST_ORD_ADD:      state_in = sts.ord_last ? ST_FINISH : ST_ORD_DBL_SAVE;
         ST_FINISH:       if (out_free) state_in = ST_IDLE;
         default:         state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '{op: OP_NONE, div_start: 1'b0, div_sel: DIV_GCD, out_load: 1'b0};
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         ST_GCD_TEST: begin
            cmd.div_sel   = DIV_GCD;
            cmd.div_start = !sts.y_zero;
         end
         ST_GCD_WAIT: begin
            cmd.div_sel = DIV_GCD;
            if (sts.div_done) cmd.op = OP_GCD_STEP;
         end
         ST_NUM_START: begin
            cmd.div_sel   = DIV_NUM;
            cmd.div_start = 1'b1;
         end
         ST_NUM_WAIT: begin
            cmd.div_sel = DIV_NUM;
            if (sts.div_done) cmd.op = OP_NUM_LOAD;
         end
         ST_DEN_START: begin
            cmd.div_sel   = DIV_DEN;
            cmd.div_start = 1'b1;
         end
         ST_DEN_WAIT: begin
            cmd.div_sel = DIV_DEN;
            if (sts.div_done) cmd.op = OP_DEN_LOAD;
         end
         ST_TWOS: begin
            if (!sts.rest_odd) cmd.op = OP_TWO_STEP;
         end
         ST_FIVES: begin
            if (sts.rest_five) cmd.op = OP_FIVE_STEP;
         end
         ST_CLASSIFY: begin
            if (!sts.rest_one) cmd.op = OP_ORD_INIT;
         end
         ST_ORD_DBL_SAVE: cmd.op = OP_DBL_SAVE;
         ST_ORD_DBL1:     cmd.op = OP_DBL;
         ST_ORD_DBL2:     cmd.op = OP_DBL;
         ST_ORD_ADD:      cmd.op = OP_ADD;
         ST_FINISH:       cmd.out_load = out_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: src/fraction_decimal_period_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_decimal_period_core
// Decimal expansion classifier: gcd reduction, preperiod and period length.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready take a numerator/denominator pair; one rsp transfer
//   follows per request, carrying the reduced fraction, the expansion kind,
//   the preperiod, the period and the repeating block's positions.
//   One fraction is worked at a time; req_ready is high only while idle.
//   Work per request: the gcd reduction (Euclid steps, then the division of
//   both terms by the gcd), the stripping of factors of two and five, then
//   the order search, one multiply-by-ten modulo rest per step, up to
//   rest - 1 steps. The shared one-bit-per-cycle divider sets the reduction
//   time; the multiply-by-ten (double and save, double, double, add) sets
//   the search time. A zero denominator skips the reduction and the search.
//   The next request is taken the cycle after the result is loaded.
//   The result sits in an output register; a new request is taken while it
//   waits for rsp_ready, and the sequencer holds in its last state only if
//   a second result is done before the first is taken.
//   Reset (synchronous) returns to idle and drops rsp_valid.
// ----------------------------------------------------------------------------
module fraction_decimal_period_core
   import fdp_pkg::*;
#(
   parameter int DEN_BITS = DEN_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   fdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fdp_datapath #(.DEN_BITS(DEN_BITS)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

// File: src/fdp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdp_checker
// Port-level assertions for fraction_decimal_period_core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fdp_checker
   import fdp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic req_wait;
   logic rsp_wait;
   logic rsp_repeats;
   logic span_ok;

   assign req_wait    = req_valid && !req_ready;
   assign rsp_wait    = rsp_valid && !rsp_ready;
   assign rsp_repeats = rsp_valid
                        && (rsp_data.kind == KIND_PURE || rsp_data.kind == KIND_MIXED);
   assign span_ok     = (rsp_data.repeat_first == 16'(rsp_data.preperiod_digits) + 16'd1)
                        && (rsp_data.period_digits != 16'd0);

   `FDP_ASSERT_NEXT(a_req_hold, clock, reset, req_wait, req_valid && $stable(req_data))
   `FDP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid)
   `FDP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_wait, $stable(rsp_data))
   `FDP_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `FDP_ASSERT_NOW(a_repeat_span, clock, reset, rsp_repeats, span_ok)

endmodule

bind fraction_decimal_period_core fdp_checker u_fdp_checker (.*);
